FILE: src/sfd_pkg.sv
// Package for the serial frame deframer: widths, payload store depth,
// register indexes, controller states and the controller/datapath bundles.
// No dependencies.
package sfd_pkg;

  localparam int ByteW      = 8;
  localparam int CmdW       = 16;
  localparam int LenW       = 6;
  localparam int IdxW       = 5;
  localparam int PayloadMax = 32;
  localparam int AddrW      = $clog2(PayloadMax);
  localparam int CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegStartByte  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxPayload = 2'd1;

  localparam logic [ByteW-1:0] StartByteRst  = 8'hFE;
  localparam logic [LenW-1:0]  MaxPayloadRst = 6'd32;
  localparam logic [LenW-1:0]  LimitCap      = LenW'(PayloadMax);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_CMDLO,
    ST_CMDHI,
    ST_DATA,
    ST_CHECK,
    ST_READ,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_len;
    logic ld_cmdlo;
    logic ld_cmdhi;
    logic ld_data;
    logic idx_clr;
    logic idx_inc;
    logic out_single;
    logic out_status;
    logic out_data;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic over_limit;
    logic len_zero;
    logic data_done;
    logic xor_match;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/sfd_if.sv
// Channel interfaces of the deframer: received bytes in, frame results out.
// Depends on sfd_pkg.
interface sfd_rx_if;
  import sfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
  import sfd_pkg::*;
  logic             valid;
  logic             ready;
  logic             status;
  logic [CmdW-1:0]  command;
  logic [LenW-1:0]  payload_len;
  logic             data_valid;
  logic [ByteW-1:0] data_byte;
  logic [IdxW-1:0]  byte_index;
  logic             last;

  modport source (output valid, output status, output command, output payload_len,
                  output data_valid, output data_byte, output byte_index,
                  output last, input ready);
  modport sink   (input valid, input status, input command, input payload_len,
                  input data_valid, input data_byte, input byte_index,
                  input last, output ready);
endinterface

FILE: src/sfd_ctrl.sv
// Frame controller: walks start, length, command, payload and check phases,
// then sequences the payload readout. Depends on sfd_pkg.
module sfd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfd_pkg::dp_stat_t stat,
  output sfd_pkg::dp_cmd_t  cmd
);
  import sfd_pkg::*;

  state_t state, state_next;
  logic   in_fire;

  always_comb begin
    case (state)
      ST_HUNT, ST_LEN, ST_CMDLO, ST_CMDHI, ST_DATA: in_ready = 1'b1;
      ST_CHECK: in_ready = stat.out_free;
      default:  in_ready = 1'b0;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_HUNT: begin
        if (in_fire && stat.is_start) state_next = ST_LEN;
      end
      ST_LEN: begin
        if (in_fire) begin
          if (!stat.over_limit) state_next = ST_CMDLO;
          else if (!stat.is_start) state_next = ST_HUNT;
        end
      end
      ST_CMDLO: begin
        if (in_fire) state_next = ST_CMDHI;
      end
      ST_CMDHI: begin
        if (in_fire) state_next = stat.len_zero ? ST_CHECK : ST_DATA;
      end
      ST_DATA: begin
        if (in_fire && stat.data_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (in_fire) begin
          state_next = (stat.xor_match && !stat.len_zero) ? ST_READ : ST_HUNT;
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) state_next = stat.emit_last ? ST_HUNT : ST_READ;
      end
      default: state_next = ST_HUNT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_LEN:   cmd.ld_len   = in_fire && !stat.over_limit;
      ST_CMDLO: cmd.ld_cmdlo = in_fire;
      ST_CMDHI: cmd.ld_cmdhi = in_fire;
      ST_DATA:  cmd.ld_data  = in_fire;
      ST_CHECK: begin
        // mismatch or empty frame: one result straight away
        cmd.out_single = in_fire && (!stat.xor_match || stat.len_zero);
        cmd.out_status = !stat.xor_match;
        cmd.idx_clr    = in_fire;
      end
      ST_EMIT: begin
        cmd.out_data = stat.out_free;
        cmd.idx_inc  = stat.out_free && !stat.emit_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/sfd_dp.sv
// Deframer datapath: configuration registers, frame fields, running XOR,
// payload store and the result output register. Depends on sfd_pkg.
module sfd_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sfd_pkg::ByteW-1:0]   cfg_data,
  input  logic [sfd_pkg::ByteW-1:0]   rx_byte,
  input  sfd_pkg::dp_cmd_t           cmd,
  output sfd_pkg::dp_stat_t          stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       status,
  output logic [sfd_pkg::CmdW-1:0]    command,
  output logic [sfd_pkg::LenW-1:0]    payload_len,
  output logic                       data_valid,
  output logic [sfd_pkg::ByteW-1:0]   data_byte,
  output logic [sfd_pkg::IdxW-1:0]    byte_index,
  output logic                       last
);
  import sfd_pkg::*;

  logic [ByteW-1:0] start_byte;
  logic [LenW-1:0]  max_payload;
  logic [LenW-1:0]  limit;
  logic [LenW-1:0]  frame_len;
  logic [CmdW-1:0]  cmd_word;
  logic [ByteW-1:0] running_xor;
  logic [LenW-1:0]  bytes_taken;
  logic [LenW:0]    taken_inc;
  logic [AddrW-1:0] idx;
  logic [ByteW-1:0] rd_data;
  logic [ByteW-1:0] payload_store [PayloadMax];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= StartByteRst;
      max_payload <= MaxPayloadRst;
    end else if (cfg_we) begin
      if (cfg_index == RegStartByte) start_byte <= cfg_data;
      if (cfg_index == RegMaxPayload) max_payload <= cfg_data[LenW-1:0];
    end
  end

  assign limit     = (max_payload > LimitCap) ? LimitCap : max_payload;
  assign taken_inc = {1'b0, bytes_taken} + (LenW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len   <= '0;
      cmd_word    <= '0;
      running_xor <= '0;
      bytes_taken <= '0;
    end else begin
      if (cmd.ld_len) begin
        frame_len   <= rx_byte[LenW-1:0];
        running_xor <= rx_byte;
        bytes_taken <= '0;
      end
      if (cmd.ld_cmdlo) begin
        cmd_word    <= {8'h00, rx_byte};
        running_xor <= running_xor ^ rx_byte;
      end
      if (cmd.ld_cmdhi) begin
        cmd_word[CmdW-1:ByteW] <= rx_byte;
        running_xor            <= running_xor ^ rx_byte;
      end
      if (cmd.ld_data) begin
        running_xor <= running_xor ^ rx_byte;
        bytes_taken <= taken_inc[LenW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_data) payload_store[bytes_taken[AddrW-1:0]] <= rx_byte;
    rd_data <= payload_store[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AddrW'(1);
    end
  end

  always_comb begin
    stat.is_start   = (rx_byte == start_byte);
    stat.over_limit = (rx_byte > {2'b00, limit});
    stat.len_zero   = (frame_len == '0);
    stat.data_done  = (taken_inc >= {1'b0, frame_len});
    stat.xor_match  = (rx_byte == running_xor);
    stat.emit_last  = (({1'b0, idx} + LenW'(1)) == frame_len);
    stat.out_free   = !out_valid || out_ready;
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_single || cmd.out_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_single) begin
      status      <= cmd.out_status;
      command     <= cmd_word;
      payload_len <= frame_len;
      data_valid  <= 1'b0;
      data_byte   <= '0;
      byte_index  <= '0;
      last        <= 1'b1;
    end else if (cmd.out_data) begin
      status      <= 1'b0;
      command     <= cmd_word;
      payload_len <= frame_len;
      data_valid  <= 1'b1;
      data_byte   <= rd_data;
      byte_index  <= IdxW'(idx);
      last        <= stat.emit_last;
    end
  end

endmodule

FILE: src/serial_frame_deframer_xor_check_unit.sv
// Top level of the serial frame deframer with XOR check byte.
// Depends on sfd_pkg, sfd_if, sfd_ctrl and sfd_dp.
//
//   port     | dir | contents
//   rx       | in  | rx_byte, one received byte per request
//   res      | out | status, command, payload_len, data_valid, data_byte,
//            |     | byte_index, last
//   cfg_*    | in  | write port: 0 start_byte, 1 max_payload
//
// Each header or payload byte is taken whenever rx.valid is high.
// A good frame of N payload bytes then reads out the payload store, one store read
// and one result load per byte, while rx is held off.
// A check byte is taken only once the result register is free; res stalls hold it.
// rst (synchronous) returns to hunting and restores the register defaults.
module serial_frame_deframer_xor_check_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sfd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sfd_pkg::ByteW-1:0]   cfg_data,
  sfd_rx_if.sink                      rx,
  sfd_res_if.source                   res
);
  import sfd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx_byte     (rx.rx_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .status      (res.status),
    .command     (res.command),
    .payload_len (res.payload_len),
    .data_valid  (res.data_valid),
    .data_byte   (res.data_byte),
    .byte_index  (res.byte_index),
    .last        (res.last)
  );

endmodule

FILE: tb/tb_serial_frame_deframer_xor_check_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_frame_deframer_xor_check_unit: directed byte
// table, then random frames under several register settings and stall patterns.
// Depends on sfd_pkg, sfd_if and the deframer RTL.
module tb_serial_frame_deframer_xor_check_unit;
  import sfd_pkg::*;

  localparam int StallLimit = 4000;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic             status;
    logic [CmdW-1:0]  command;
    logic [LenW-1:0]  payload_len;
    logic             data_valid;
    logic [ByteW-1:0] data_byte;
    logic [IdxW-1:0]  byte_index;
    logic             last;
  } frame_res_t;

  typedef struct packed {
    logic             typed;
    frame_res_t       want;
    logic [ByteW-1:0] rx;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [ByteW-1:0]    cfg_data;

  sfd_rx_if  rx_ch ();
  sfd_res_if res_ch ();

  serial_frame_deframer_xor_check_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx       (rx_ch),
    .res      (res_ch)
  );

  // Deframer shadow state and register copies
  logic [ByteW-1:0] start_cfg;
  logic [LenW-1:0]  maxp_cfg;
  state_t           fr_phase;
  logic [LenW-1:0]  fr_len;
  logic [CmdW-1:0]  fr_cmd;
  logic [ByteW-1:0] fr_xor;
  logic [LenW-1:0]  fr_taken;
  logic [ByteW-1:0] payload_mem [PayloadMax];

  frame_res_t step_results [$];
  frame_res_t frame_results_q [$];
  dir_row_t   dir_rows [$];
  frame_res_t seen_res;
  frame_res_t want_res;

  int send_gap_pct;
  int recv_gap_pct;
  int items_done;
  int bytes_in;
  int results_seen;
  int good_frames;
  int bad_frames;
  int fail_count;
  int mismatch_count;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the results that one received byte causes.
  function automatic void deframe_byte(input logic [ByteW-1:0] b);
    int lim;
    int i;
    frame_res_t r;
    step_results.delete();
    lim = (int'(maxp_cfg) > PayloadMax) ? PayloadMax : int'(maxp_cfg);
    r = '0;
    case (fr_phase)
      ST_HUNT: begin
        if (b == start_cfg) fr_phase = ST_LEN;
      end
      ST_LEN: begin
        if (int'(b) > lim) begin
          // overlong length: retry it as a start byte
          fr_phase = (b == start_cfg) ? ST_LEN : ST_HUNT;
        end else begin
          fr_len   = b[LenW-1:0];
          fr_xor   = b;
          fr_taken = '0;
          fr_phase = ST_CMDLO;
        end
      end
      ST_CMDLO: begin
        fr_cmd   = {8'h00, b};
        fr_xor   = fr_xor ^ b;
        fr_phase = ST_CMDHI;
      end
      ST_CMDHI: begin
        fr_cmd[15:8] = b;
        fr_xor       = fr_xor ^ b;
        fr_phase     = (fr_len == 0) ? ST_CHECK : ST_DATA;
      end
      ST_DATA: begin
        if (int'(fr_taken) < PayloadMax) payload_mem[fr_taken[AddrW-1:0]] = b;
        fr_xor   = fr_xor ^ b;
        fr_taken = fr_taken + LenW'(1);
        if (fr_taken >= fr_len) fr_phase = ST_CHECK;
      end
      ST_CHECK: begin
        r.command     = fr_cmd;
        r.payload_len = fr_len;
        r.last        = 1'b1;
        if (b != fr_xor) begin
          r.status = 1'b1;
          step_results.push_back(r);
        end else if (fr_len == 0) begin
          step_results.push_back(r);
        end else begin
          for (i = 0; i < int'(fr_len) && i < PayloadMax; i++) begin
            r.data_valid = 1'b1;
            r.data_byte  = payload_mem[i];
            r.byte_index = i[IdxW-1:0];
            r.last       = (i + 1 == int'(fr_len));
            step_results.push_back(r);
          end
        end
        fr_phase = ST_HUNT;
      end
      default: fr_phase = ST_HUNT;
    endcase
  endfunction

  // Present one byte, hold it until the request is taken, then predict.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed = 1'b0,
                           input frame_res_t want = '0);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    bytes_in++;
    deframe_byte(b);
    if (typed) begin
      frame_results_q.push_back(want);
    end else begin
      foreach (step_results[k]) frame_results_q.push_back(step_results[k]);
    end
  endtask

  // One random frame: optional noise, start, maybe a broken length, body, check.
  task automatic send_frame();
    int lim;
    int n_noise;
    int plen;
    int i;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] chk;
    lim = (int'(maxp_cfg) > PayloadMax) ? PayloadMax : int'(maxp_cfg);
    n_noise = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < n_noise; i++) begin
      b = 8'($urandom);
      if (b == start_cfg) b = b ^ 8'h01;
      send_byte(b);
      items_done++;
    end
    send_byte(start_cfg);
    items_done++;
    if ($urandom_range(0, 9) == 0) begin
      if (start_cfg > lim && $urandom_range(0, 2) == 0) b = start_cfg;
      else b = 8'($urandom_range(lim + 1, 255));
      send_byte(b);
      items_done++;
      if (b != start_cfg) return;
    end
    plen = ($urandom_range(0, 4) == 0) ? lim : $urandom_range(0, (lim < 6) ? lim : 6);
    chk = 8'(plen);
    send_byte(8'(plen));
    items_done++;
    for (i = 0; i < plen + 2; i++) begin
      b   = 8'($urandom);
      chk = chk ^ b;
      send_byte(b);
      items_done++;
    end
    if ($urandom_range(0, 6) == 0) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(chk);
    items_done++;
  endtask

  task automatic write_regs(input logic [ByteW-1:0] sb, input logic [LenW-1:0] mp);
    cfg_we    <= 1'b1;
    cfg_index <= RegStartByte;
    cfg_data  <= sb;
    @(posedge clk);
    start_cfg = sb;
    cfg_index <= RegMaxPayload;
    cfg_data  <= {2'b00, mp};
    @(posedge clk);
    maxp_cfg = mp;
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: random backpressure and result checking
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        seen_res = '{res_ch.status, res_ch.command, res_ch.payload_len, res_ch.data_valid,
                     res_ch.data_byte, res_ch.byte_index, res_ch.last};
        results_seen++;
        if (seen_res.status) bad_frames++;
        else if (seen_res.last) good_frames++;
        if (frame_results_q.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing pending: %p", $realtime, seen_res);
        end else begin
          want_res = frame_results_q.pop_front();
          if (seen_res !== want_res) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp %p got %p", $realtime, want_res, seen_res);
          end
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // Watchdog: count cycles with no request taken on either channel
  always @(posedge clk) begin
    if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk);
    $display("timeout after %0d idle cycles, %0d results pending", quiet_cycles,
             frame_results_q.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [ByteW-1:0] ph_start [4] = '{8'h7E, 8'h00, 8'hFF, 8'hA5};
    logic [LenW-1:0]  ph_maxp  [4] = '{6'd32, 6'd0, 6'd63, 6'd5};
    int               ph_items [4] = '{90, 30, 80, 70};
    int               ph_send  [4] = '{34, 34, 54, 0};
    int               ph_recv  [4] = '{54, 54, 34, 0};
    int               p;
    int               missing;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= RegStartByte;
    cfg_data      <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    send_gap_pct = 34;
    recv_gap_pct = 54;
    start_cfg    = StartByteRst;
    maxp_cfg     = MaxPayloadRst;
    fr_phase     = ST_HUNT;
    fr_len       = '0;
    fr_cmd       = '0;
    fr_xor       = '0;
    fr_taken     = '0;
    foreach (payload_mem[k]) payload_mem[k] = '0;

    // Directed bytes under the reset register values
    dir_rows.push_back('{1'b0, '0, 8'h00});                    // noise while hunting
    dir_rows.push_back('{1'b0, '0, 8'hFE});                    // start
    dir_rows.push_back('{1'b0, '0, 8'h00});                    // empty payload
    dir_rows.push_back('{1'b0, '0, 8'hFF});
    dir_rows.push_back('{1'b0, '0, 8'hFF});
    dir_rows.push_back('{1'b1, '{1'b0, 16'hFFFF, 6'd0, 1'b0, 8'h00, 5'd0, 1'b1}, 8'h00});
    dir_rows.push_back('{1'b0, '0, 8'hFE});
    dir_rows.push_back('{1'b0, '0, 8'hFE});                    // overlong, is a start
    dir_rows.push_back('{1'b0, '0, 8'h01});
    dir_rows.push_back('{1'b0, '0, 8'h34});
    dir_rows.push_back('{1'b0, '0, 8'h12});
    dir_rows.push_back('{1'b0, '0, 8'hAB});
    dir_rows.push_back('{1'b1, '{1'b1, 16'h1234, 6'd1, 1'b0, 8'h00, 5'd0, 1'b1}, 8'h00});
    dir_rows.push_back('{1'b0, '0, 8'hFE});
    dir_rows.push_back('{1'b0, '0, 8'h21});                    // one above the limit
    dir_rows.push_back('{1'b0, '0, 8'h21});                    // noise, still hunting
    dir_rows.push_back('{1'b0, '0, 8'hFE});
    dir_rows.push_back('{1'b0, '0, 8'h02});
    dir_rows.push_back('{1'b0, '0, 8'h00});
    dir_rows.push_back('{1'b0, '0, 8'h80});
    dir_rows.push_back('{1'b0, '0, 8'hFF});
    dir_rows.push_back('{1'b0, '0, 8'h00});
    dir_rows.push_back('{1'b0, '0, 8'h7D});                    // good two-byte frame

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
    rx_ch.valid <= 1'b0;
    wait_drained();

    for (p = 0; p < 4; p++) begin
      send_gap_pct = ph_send[p];
      recv_gap_pct = ph_recv[p];
      write_regs(ph_start[p], ph_maxp[p]);
      items_done = 0;
      while (items_done < ph_items[p]) send_frame();
      rx_ch.valid <= 1'b0;
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    missing = frame_results_q.size();
    if (missing != 0) begin
      $display("%0d expected results never arrived", missing);
    end
    $display("sent %0d bytes over 5 register settings, checked %0d results",
             bytes_in, results_seen);
    $display("%0d good frames, %0d check byte errors, %0d failures",
             good_frames, bad_frames, fail_count);
    if (fail_count == 0 && missing == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sfd_pkg.sv
src/sfd_if.sv
src/sfd_ctrl.sv
src/sfd_dp.sv
src/serial_frame_deframer_xor_check_unit.sv
tb/tb_serial_frame_deframer_xor_check_unit.sv
